FILE: rtl/core/mstd_pkg.sv
// ----------------------------------------------------------------------------
// mstd_pkg
// Shared widths, defaults and control types for the four-channel mean and
// standard deviation block.
// ----------------------------------------------------------------------------
package mstd_pkg;

  localparam int NUM_CH           = 4;
  localparam int SCORE_W          = 8;
  localparam int CNT_W            = 17;
  localparam int SUM_W            = 24;
  localparam int SQ_W             = 32;
  localparam int MEAN_W           = 16;
  localparam int DEV_W            = 15;
  localparam int MAX_W            = 25;
  localparam int DEF_MAX_RECORDS  = 65536;
  localparam int DEF_SCORE_BITS   = 8;

  // per-lane accumulator control
  typedef struct packed {
    logic add;
    logic clr;
  } lane_ctl_t;

  // per-lane final statistic
  typedef struct packed {
    logic              done;
    logic [MEAN_W-1:0] mean;
    logic [DEV_W-1:0]  dev;
  } stat_res_t;

endpackage

FILE: rtl/core/mstd_in_if.sv
// ----------------------------------------------------------------------------
// mstd_in_if
// Record channel: valid/ready handshake with one record as payload.
// ----------------------------------------------------------------------------
interface mstd_in_if;
  logic                        valid;
  logic                        ready;
  logic                        is_present;
  logic [mstd_pkg::SCORE_W-1:0] score_lang;
  logic [mstd_pkg::SCORE_W-1:0] score_math;
  logic [mstd_pkg::SCORE_W-1:0] score_nat;
  logic [mstd_pkg::SCORE_W-1:0] score_hum;
  logic                        last_item;

  modport source (output valid, is_present, score_lang, score_math, score_nat,
                  score_hum, last_item, input ready);
  modport sink   (input valid, is_present, score_lang, score_math, score_nat,
                  score_hum, last_item, output ready);
endinterface

FILE: rtl/core/mstd_out_if.sv
// ----------------------------------------------------------------------------
// mstd_out_if
// Result channel: valid/ready handshake with one set's statistics.
// ----------------------------------------------------------------------------
interface mstd_out_if;
  logic                         valid;
  logic                         ready;
  logic [mstd_pkg::MEAN_W-1:0]  mean_lang;
  logic [mstd_pkg::MEAN_W-1:0]  mean_math;
  logic [mstd_pkg::MEAN_W-1:0]  mean_nat;
  logic [mstd_pkg::MEAN_W-1:0]  mean_hum;
  logic [mstd_pkg::DEV_W-1:0]   dev_lang;
  logic [mstd_pkg::DEV_W-1:0]   dev_math;
  logic [mstd_pkg::DEV_W-1:0]   dev_nat;
  logic [mstd_pkg::DEV_W-1:0]   dev_hum;
  logic [mstd_pkg::CNT_W-1:0]   present_count;
  logic                         none_present;

  modport source (output valid, mean_lang, mean_math, mean_nat, mean_hum,
                  dev_lang, dev_math, dev_nat, dev_hum, present_count,
                  none_present, input ready);
  modport sink   (input valid, mean_lang, mean_math, mean_nat, mean_hum,
                  dev_lang, dev_math, dev_nat, dev_hum, present_count,
                  none_present, output ready);
endinterface

FILE: rtl/core/mean_and_std_deviation_four_channel.sv
// ----------------------------------------------------------------------------
// mean_and_std_deviation_four_channel
// Four-lane population mean and standard deviation over a set of records.
// ----------------------------------------------------------------------------
// Throughput: one record per cycle while a set accumulates.
// After the closing record is taken, the result passes through start, load,
//   multiply, subtract, the 64-step divider and 32-step square root in each
//   lane, and the merge register before it is valid.
// Records are not taken while the lanes compute the final statistics.
// Reset clears the count, all sums and the result valid.
module mean_and_std_deviation_four_channel #(
  parameter int MAX_RECORDS = mstd_pkg::DEF_MAX_RECORDS,
  parameter int SCORE_BITS  = mstd_pkg::DEF_SCORE_BITS
) (
  input  logic       clk,
  input  logic       rst,
  mstd_in_if.sink    in_ch,
  mstd_out_if.source out_ch
);
  import mstd_pkg::*;

  typedef enum logic [2:0] {
    T_ACC  = 3'b001,
    T_CALC = 3'b010,
    T_OUT  = 3'b100
  } state_t;

  localparam logic [MAX_W-1:0] MaxRec = MAX_W'(MAX_RECORDS);

  state_t           state;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] n_res;
  logic             start;
  logic             in_acc;
  logic             out_acc;
  logic             add;
  logic             close;
  lane_ctl_t        ctl;

  logic [SCORE_W-1:0] score [NUM_CH];
  logic [SUM_W-1:0]   sum   [NUM_CH];
  logic [SQ_W-1:0]    sqs   [NUM_CH];
  stat_res_t          res   [NUM_CH];
  logic               all_done;

  assign in_ch.ready = (state == T_ACC) || ((state == T_OUT) && out_ch.ready);
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;
  assign add     = in_acc && in_ch.is_present &&
                   ({{(MAX_W-CNT_W){1'b0}}, count} < MaxRec);
  assign close   = in_acc && in_ch.last_item;
  assign ctl.add = add;
  assign ctl.clr = start;

  assign score[0] = in_ch.score_lang;
  assign score[1] = in_ch.score_math;
  assign score[2] = in_ch.score_nat;
  assign score[3] = in_ch.score_hum;

  for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
    mstd_lane #(.SCORE_BITS(SCORE_BITS)) u_lane (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .score     (score[c]),
      .sum       (sum[c]),
      .square_sum(sqs[c])
    );
    mstd_stat u_stat (
      .clk       (clk),
      .rst       (rst),
      .start     (start),
      .n         (count),
      .sum       (sum[c]),
      .square_sum(sqs[c]),
      .res       (res[c])
    );
  end

  assign all_done = res[0].done && res[1].done && res[2].done && res[3].done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= T_ACC;
      count        <= '0;
      start        <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      start <= 1'b0;
      if (start) begin
        n_res <= count;
        count <= '0;
      end else if (add) begin
        count <= count + CNT_W'(1);
      end
      unique case (state)
        T_ACC: begin
          if (close) begin
            start <= 1'b1;
            state <= T_CALC;
          end
        end
        T_CALC: begin
          if (all_done) begin
            out_ch.valid <= 1'b1;
            state        <= T_OUT;
          end
        end
        T_OUT: begin
          if (out_acc) begin
            out_ch.valid <= 1'b0;
            if (close) begin
              start <= 1'b1;
              state <= T_CALC;
            end else begin
              state <= T_ACC;
            end
          end
        end
        default: state <= T_ACC;
      endcase
    end
  end

  // merge the lane results; an empty set reports zeros
  always_ff @(posedge clk) begin
    if (state == T_CALC && all_done) begin
      out_ch.none_present  <= (n_res == '0);
      out_ch.present_count <= n_res;
      out_ch.mean_lang <= (n_res == '0) ? '0 : res[0].mean;
      out_ch.mean_math <= (n_res == '0) ? '0 : res[1].mean;
      out_ch.mean_nat  <= (n_res == '0) ? '0 : res[2].mean;
      out_ch.mean_hum  <= (n_res == '0) ? '0 : res[3].mean;
      out_ch.dev_lang  <= (n_res == '0) ? '0 : res[0].dev;
      out_ch.dev_math  <= (n_res == '0) ? '0 : res[1].dev;
      out_ch.dev_nat   <= (n_res == '0) ? '0 : res[2].dev;
      out_ch.dev_hum   <= (n_res == '0) ? '0 : res[3].dev;
    end
  end

  a_calc_no_valid: assert property (@(posedge clk) disable iff (rst)
    (state == T_CALC) |-> !out_ch.valid)
    else $error("result valid while lanes still compute");

  a_close_starts: assert property (@(posedge clk) disable iff (rst)
    close |=> (start && state == T_CALC))
    else $error("closing record did not start the lanes");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.none_present) |->
      (out_ch.mean_lang == '0 && out_ch.dev_hum == '0 && out_ch.present_count == '0))
    else $error("empty set reported nonzero statistics");

  a_no_ready_calc: assert property (@(posedge clk) disable iff (rst)
    (state == T_CALC) |-> !in_ch.ready)
    else $error("record taken during final computation");

endmodule

FILE: rtl/core/mstd_lane.sv
// ----------------------------------------------------------------------------
// mstd_lane
// One channel accumulator: running sum and sum of squares of the scores.
// ----------------------------------------------------------------------------
module mstd_lane #(
  parameter int SCORE_BITS = mstd_pkg::DEF_SCORE_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mstd_pkg::lane_ctl_t           ctl,
  input  logic [mstd_pkg::SCORE_W-1:0]  score,
  output logic [mstd_pkg::SUM_W-1:0]    sum,
  output logic [mstd_pkg::SQ_W-1:0]     square_sum
);
  import mstd_pkg::*;

  localparam logic [SCORE_W-1:0] ScoreMask =
    (SCORE_BITS >= SCORE_W) ? {SCORE_W{1'b1}} : SCORE_W'((1 << SCORE_BITS) - 1);

  logic [SCORE_W-1:0]   s;
  logic [2*SCORE_W-1:0] sq;

  assign s  = score & ScoreMask;
  assign sq = s * s;

  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      sum        <= '0;
      square_sum <= '0;
    end else if (ctl.add) begin
      sum        <= sum + SUM_W'(s);
      square_sum <= square_sum + SQ_W'(sq);
    end
  end

endmodule

FILE: rtl/core/mstd_stat.sv
// ----------------------------------------------------------------------------
// mstd_stat
// End-of-set unit for one channel: mean by restoring division, deviation by
// division of the scaled variance and a digit-by-digit square root.
// ----------------------------------------------------------------------------
module mstd_stat (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [mstd_pkg::CNT_W-1:0]  n,
  input  logic [mstd_pkg::SUM_W-1:0]  sum,
  input  logic [mstd_pkg::SQ_W-1:0]   square_sum,
  output mstd_pkg::stat_res_t         res
);
  import mstd_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_SUB  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_SQRT = 5'b10000
  } state_t;

  state_t state;
  logic             done;
  logic [CNT_W-1:0] n_r;
  logic [SUM_W-1:0] s_r;
  logic [SQ_W-1:0]  q_r;
  logic [48:0]      nq;
  logic [47:0]      ss;
  logic [33:0]      nn;
  logic [63:0]      x_sh;
  logic [34:0]      rem_d;
  logic [31:0]      m_sh;
  logic [17:0]      rem_m;
  logic [33:0]      rem_s;
  logic [31:0]      root;
  logic [5:0]       cnt;

  logic [48:0] d;
  logic [34:0] rem_d_sh;
  logic [17:0] rem_m_sh;
  logic [33:0] rem_s_sh;
  logic [33:0] trial;

  assign d        = (nq > {1'b0, ss}) ? (nq - {1'b0, ss}) : '0;
  assign rem_d_sh = {rem_d[33:0], x_sh[63]};
  assign rem_m_sh = {rem_m[16:0], m_sh[31]};
  assign rem_s_sh = {rem_s[31:0], x_sh[63:62]};
  assign trial    = {root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            n_r   <= n;
            s_r   <= sum;
            q_r   <= square_sum;
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          nq    <= 49'(n_r) * 49'(q_r);
          ss    <= 48'(s_r) * 48'(s_r);
          nn    <= 34'(n_r) * 34'(n_r);
          state <= ST_SUB;
        end
        ST_SUB: begin
          // keep only what survives a 64-bit left shift by 16
          x_sh  <= {d[47:0], 16'b0};
          rem_d <= '0;
          m_sh  <= {s_r, 8'b0};
          rem_m <= '0;
          cnt   <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (rem_d_sh >= {1'b0, nn}) begin
            rem_d <= rem_d_sh - {1'b0, nn};
            x_sh  <= {x_sh[62:0], 1'b1};
          end else begin
            rem_d <= rem_d_sh;
            x_sh  <= {x_sh[62:0], 1'b0};
          end
          // mean division runs over the first half of the count
          if (!cnt[5]) begin
            if (rem_m_sh >= {1'b0, n_r}) begin
              rem_m <= rem_m_sh - {1'b0, n_r};
              m_sh  <= {m_sh[30:0], 1'b1};
            end else begin
              rem_m <= rem_m_sh;
              m_sh  <= {m_sh[30:0], 1'b0};
            end
          end
          cnt <= cnt + 6'd1;
          if (cnt == 6'd63) begin
            rem_s <= '0;
            root  <= '0;
            state <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          x_sh <= {x_sh[61:0], 2'b00};
          if (rem_s_sh >= trial) begin
            rem_s <= rem_s_sh - trial;
            root  <= {root[30:0], 1'b1};
          end else begin
            rem_s <= rem_s_sh;
            root  <= {root[30:0], 1'b0};
          end
          cnt <= cnt + 6'd1;
          if (cnt[4:0] == 5'd31) begin
            done  <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign res.done = done;
  assign res.mean = m_sh[MEAN_W-1:0];
  assign res.dev  = root[DEV_W-1:0];

endmodule
